// ===== rtl/assert_macros.svh =====
// assertion macros shared by the convexity check rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define PCC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pcc assertion failed");

// consequence that must hold in the cycle after the antecedent
`define PCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcc assertion failed");

`else

`define PCC_ASSERT(lbl, clk, rst, prop)
`define PCC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/pcc_pkg.sv =====
// shared types and constants of the polygon convexity check
package pcc_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int MIN_VERTICES   = 3;
   localparam int QUEUE_DEPTH    = 4;
   localparam int NUM_PTS        = 5;
   localparam int NUM_LANES      = 3;
   localparam int PT_BITS        = $clog2(NUM_PTS);

   // points carried by one job
   localparam logic [PT_BITS-1:0] PT_OLDER  = PT_BITS'(0);
   localparam logic [PT_BITS-1:0] PT_NEWER  = PT_BITS'(1);
   localparam logic [PT_BITS-1:0] PT_CUR    = PT_BITS'(2);
   localparam logic [PT_BITS-1:0] PT_FIRST  = PT_BITS'(3);
   localparam logic [PT_BITS-1:0] PT_SECOND = PT_BITS'(4);

   // turn lanes: regular turn, then the two wrap-around turns
   localparam logic [PT_BITS-1:0] LANE_A [NUM_LANES] = '{PT_OLDER, PT_NEWER, PT_CUR};
   localparam logic [PT_BITS-1:0] LANE_B [NUM_LANES] = '{PT_NEWER, PT_CUR, PT_FIRST};
   localparam logic [PT_BITS-1:0] LANE_C [NUM_LANES] = '{PT_CUR, PT_FIRST, PT_SECOND};

   typedef enum logic [1:0] {
      SIGN_NONE = 2'd0,
      SIGN_POS  = 2'd1,
      SIGN_NEG  = 2'd2
   } turn_sign_type;

   typedef struct packed {
      logic turn_en;
      logic wrap_en;
      logic last;
      logic short_poly;
   } pcc_ctl_type;

endpackage

// ===== rtl/pcc_front.sv =====
// front end: vertex history and turn job classification
module pcc_front #(
   parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic signed [COORD_BITS-1:0] vertex_x,
   input  logic signed [COORD_BITS-1:0] vertex_y,
   input  logic                         last_vertex,
   output pcc_pkg::pcc_ctl_type         job_ctl,
   output logic signed [COORD_BITS-1:0] job_x [pcc_pkg::NUM_PTS],
   output logic signed [COORD_BITS-1:0] job_y [pcc_pkg::NUM_PTS]
);
   import pcc_pkg::*;

   localparam logic [1:0] CNT_SAT  = 2'(MIN_VERTICES);
   localparam logic [1:0] CNT_TURN = 2'(MIN_VERTICES - 1);

   logic [1:0]                  count_ff, count_in;
   logic signed [COORD_BITS-1:0] first_x_ff, first_y_ff, second_x_ff, second_y_ff;
   logic signed [COORD_BITS-1:0] older_x_ff, older_y_ff, newer_x_ff, newer_y_ff;
   logic                        has_turn;

   assign has_turn = (count_ff >= CNT_TURN);

   always_comb begin
      job_ctl.turn_en    = has_turn;
      job_ctl.wrap_en    = last_vertex && has_turn;
      job_ctl.last       = last_vertex;
      job_ctl.short_poly = last_vertex && !has_turn;
      job_x[PT_OLDER]    = older_x_ff;
      job_y[PT_OLDER]    = older_y_ff;
      job_x[PT_NEWER]    = newer_x_ff;
      job_y[PT_NEWER]    = newer_y_ff;
      job_x[PT_CUR]      = vertex_x;
      job_y[PT_CUR]      = vertex_y;
      job_x[PT_FIRST]    = first_x_ff;
      job_y[PT_FIRST]    = first_y_ff;
      job_x[PT_SECOND]   = second_x_ff;
      job_y[PT_SECOND]   = second_y_ff;
   end

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (last_vertex) begin
            count_in = 2'd0;
         end else if (count_ff < CNT_SAT) begin
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (count_ff == 2'd0) begin
            first_x_ff <= vertex_x;
            first_y_ff <= vertex_y;
         end
         if (count_ff == 2'd1) begin
            second_x_ff <= vertex_x;
            second_y_ff <= vertex_y;
         end
         older_x_ff <= newer_x_ff;
         older_y_ff <= newer_y_ff;
         newer_x_ff <= vertex_x;
         newer_y_ff <= vertex_y;
      end
   end

endmodule

// ===== rtl/pcc_queue.sv =====
// job queue between the front end and the turn datapath
`include "assert_macros.svh"

module pcc_queue #(
   parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  pcc_pkg::pcc_ctl_type         wr_ctl,
   input  logic signed [COORD_BITS-1:0] wr_x [pcc_pkg::NUM_PTS],
   input  logic signed [COORD_BITS-1:0] wr_y [pcc_pkg::NUM_PTS],
   input  logic                         pop,
   output logic                         empty,
   output logic                         full,
   output pcc_pkg::pcc_ctl_type         rd_ctl,
   output logic signed [COORD_BITS-1:0] rd_x [pcc_pkg::NUM_PTS],
   output logic signed [COORD_BITS-1:0] rd_y [pcc_pkg::NUM_PTS]
);
   import pcc_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

   pcc_ctl_type                  ctl_ff [QUEUE_DEPTH];
   logic signed [COORD_BITS-1:0] x_ff   [QUEUE_DEPTH][NUM_PTS];
   logic signed [COORD_BITS-1:0] y_ff   [QUEUE_DEPTH][NUM_PTS];
   logic [PTR_BITS-1:0]          wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0]          count_ff, count_in;
   logic                         do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_FULL);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   assign rd_ctl = ctl_ff[rd_ptr_ff];
   assign rd_x   = x_ff[rd_ptr_ff];
   assign rd_y   = y_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_BITS'(1);
         2'b01:   count_in = count_ff - CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= PTR_BITS'(wr_ptr_ff + PTR_BITS'(1));
         end
         if (do_pop) begin
            rd_ptr_ff <= PTR_BITS'(rd_ptr_ff + PTR_BITS'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ctl_ff[wr_ptr_ff] <= wr_ctl;
         x_ff[wr_ptr_ff]   <= wr_x;
         y_ff[wr_ptr_ff]   <= wr_y;
      end
   end

   `PCC_ASSERT(a_queue_bound, clock, reset, count_ff <= CNT_FULL)
   `PCC_ASSERT_NEXT(a_queue_grow, clock, reset, do_push && !do_pop,
      count_ff == $past(count_ff) + CNT_BITS'(1))
   `PCC_ASSERT(a_ptr_gap, clock, reset, wr_ptr_ff == PTR_BITS'(rd_ptr_ff + count_ff))

endmodule

// ===== rtl/pcc_back.sv =====
// back end: cross products, turn signs and per-polygon verdict
`include "assert_macros.svh"

module pcc_back #(
   parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   input  pcc_pkg::pcc_ctl_type         job_ctl,
   input  logic signed [COORD_BITS-1:0] job_x [pcc_pkg::NUM_PTS],
   input  logic signed [COORD_BITS-1:0] job_y [pcc_pkg::NUM_PTS],
   output logic                         job_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_is_convex_flag,
   output logic                         rsp_error_code
);
   import pcc_pkg::*;

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int TURN_BITS = PROD_BITS + 1;

   logic                        advance;
   logic                        s1_valid_ff, s2_valid_ff;
   pcc_ctl_type                 s1_ctl_ff, s2_ctl_ff;
   logic signed [PROD_BITS-1:0] prod_l_ff [NUM_LANES];
   logic signed [PROD_BITS-1:0] prod_r_ff [NUM_LANES];
   logic [NUM_LANES-1:0]        lane_en, pos_in, neg_in, pos_ff, neg_ff;
   logic                        pos_any, neg_any;
   turn_sign_type               turn_sign_ff, turn_sign_in, sign_seen;
   logic                        conflict_seen_ff, conflict_seen_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_is_convex_ff, rsp_error_ff;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign job_pop = advance && job_valid;

   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      logic signed [DIFF_BITS-1:0] ab_x, ab_y, bc_x, bc_y;
      logic signed [TURN_BITS-1:0] turn;

      assign ab_x = DIFF_BITS'(job_x[LANE_B[k]]) - DIFF_BITS'(job_x[LANE_A[k]]);
      assign ab_y = DIFF_BITS'(job_y[LANE_B[k]]) - DIFF_BITS'(job_y[LANE_A[k]]);
      assign bc_x = DIFF_BITS'(job_x[LANE_C[k]]) - DIFF_BITS'(job_x[LANE_B[k]]);
      assign bc_y = DIFF_BITS'(job_y[LANE_C[k]]) - DIFF_BITS'(job_y[LANE_B[k]]);

      always_ff @(posedge clock) begin
         if (advance) begin
            prod_l_ff[k] <= PROD_BITS'(ab_x * bc_y);
            prod_r_ff[k] <= PROD_BITS'(ab_y * bc_x);
         end
      end

      assign turn = TURN_BITS'(prod_l_ff[k]) - TURN_BITS'(prod_r_ff[k]);

      if (k == 0) begin : g_reg
         assign lane_en[k] = s1_ctl_ff.turn_en;
      end else begin : g_wrap
         assign lane_en[k] = s1_ctl_ff.wrap_en;
      end

      assign neg_in[k] = lane_en[k] && turn[TURN_BITS-1];
      assign pos_in[k] = lane_en[k] && !turn[TURN_BITS-1] && (turn != '0);
   end

   assign pos_any = |pos_ff;
   assign neg_any = |neg_ff;

   always_comb begin
      if (pos_any) begin
         sign_seen = SIGN_POS;
      end else if (neg_any) begin
         sign_seen = SIGN_NEG;
      end else begin
         sign_seen = SIGN_NONE;
      end
      turn_sign_in     = (turn_sign_ff != SIGN_NONE) ? turn_sign_ff : sign_seen;
      conflict_seen_in = conflict_seen_ff || (pos_any && neg_any)
                      || (turn_sign_ff == SIGN_POS && neg_any)
                      || (turn_sign_ff == SIGN_NEG && pos_any);
      rsp_valid_in     = s2_valid_ff && s2_ctl_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         turn_sign_ff     <= SIGN_NONE;
         conflict_seen_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= job_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (s2_valid_ff) begin
            if (s2_ctl_ff.last) begin
               turn_sign_ff     <= SIGN_NONE;
               conflict_seen_ff <= 1'b0;
            end else begin
               turn_sign_ff     <= turn_sign_in;
               conflict_seen_ff <= conflict_seen_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ctl_ff <= job_ctl;
         s2_ctl_ff <= s1_ctl_ff;
         pos_ff    <= pos_in;
         neg_ff    <= neg_in;
         if (rsp_valid_in) begin
            rsp_is_convex_ff <= !s2_ctl_ff.short_poly && !conflict_seen_in;
            rsp_error_ff     <= s2_ctl_ff.short_poly;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_convex_flag = rsp_is_convex_ff;
   assign rsp_error_code     = rsp_error_ff;

   `PCC_ASSERT(a_conflict_has_sign, clock, reset,
      !conflict_seen_ff || turn_sign_ff != SIGN_NONE)
   `PCC_ASSERT(a_error_not_convex, clock, reset,
      !rsp_valid_ff || !rsp_error_ff || !rsp_is_convex_ff)
   `PCC_ASSERT_NEXT(a_verdict_clears, clock, reset,
      advance && s2_valid_ff && s2_ctl_ff.last,
      turn_sign_ff == SIGN_NONE && !conflict_seen_ff)

endmodule

// ===== rtl/polygon_convexity_check.sv =====
// top level of the polygon convexity check
//
//  channel  direction  fields                                   handshake
//  req_     in         vertex_x, vertex_y, last_vertex           valid / stall
//  rsp_     out        is_convex_flag, error_code (last vertex)  valid / stall
//
// one vertex is taken per cycle unless the queue is full; each job needs one pass
// through the turn lanes; a verdict passes the queue entry, the product registers,
// the sign registers and the verdict register after its last vertex is taken
// a four-entry job queue parts the front end from the turn datapath
// reset is synchronous and clears the vertex count, queue and turn state
// req_stall rises only when the queue is full; rsp_stall holds the datapath
module polygon_convexity_check #(
   parameter int COORD_BITS = pcc_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_vertex_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_y,
   input  logic                         req_last_vertex,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_is_convex_flag,
   output logic                         rsp_error_code
);
   import pcc_pkg::*;

   logic                         accept, q_empty, q_full, q_pop;
   pcc_ctl_type                  front_ctl, q_ctl;
   logic signed [COORD_BITS-1:0] front_x [NUM_PTS];
   logic signed [COORD_BITS-1:0] front_y [NUM_PTS];
   logic signed [COORD_BITS-1:0] q_x     [NUM_PTS];
   logic signed [COORD_BITS-1:0] q_y     [NUM_PTS];

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   pcc_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .vertex_x    (req_vertex_x),
      .vertex_y    (req_vertex_y),
      .last_vertex (req_last_vertex),
      .job_ctl     (front_ctl),
      .job_x       (front_x),
      .job_y       (front_y)
   );

   pcc_queue #(.COORD_BITS(COORD_BITS)) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (accept),
      .wr_ctl (front_ctl),
      .wr_x   (front_x),
      .wr_y   (front_y),
      .pop    (q_pop),
      .empty  (q_empty),
      .full   (q_full),
      .rd_ctl (q_ctl),
      .rd_x   (q_x),
      .rd_y   (q_y)
   );

   pcc_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (!q_empty),
      .job_ctl            (q_ctl),
      .job_x              (q_x),
      .job_y              (q_y),
      .job_pop            (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_is_convex_flag (rsp_is_convex_flag),
      .rsp_error_code     (rsp_error_code)
   );

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench of the polygon convexity check
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pcc_pkg::*;

   localparam int CB           = COORD_BITS_DEF;
   localparam int IDLE_PCT     = 38;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES  = 80;
   localparam int WATCHDOG_MAX = 2000;

   typedef struct packed {
      logic convex;
      logic error;
   } verdict_type;

   typedef struct packed {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
   } point_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [CB-1:0] req_vertex_x;
   logic signed [CB-1:0] req_vertex_y;
   logic                 req_last_vertex;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_is_convex_flag;
   logic                 rsp_error_code;

   polygon_convexity_check #(.COORD_BITS(CB)) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_vertex_x       (req_vertex_x),
      .req_vertex_y       (req_vertex_y),
      .req_last_vertex    (req_last_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_is_convex_flag (rsp_is_convex_flag),
      .rsp_error_code     (rsp_error_code)
   );

   // shadow state of the convexity tracker
   logic signed [CB-1:0] p_first_x, p_first_y, p_second_x, p_second_y;
   logic signed [CB-1:0] p_older_x, p_older_y, p_newer_x, p_newer_y;
   logic [1:0]           p_count;
   turn_sign_type        p_sign;
   logic                 p_conflict;

   verdict_type expected_verdicts[$];
   point_type   shape_pts[$];
   int       fail_count;
   bit       idle_en;
   bit       hold_req;
   int       hold_left;
   int       quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit idle_now();
      return idle_en && ($urandom_range(99) < IDLE_PCT);
   endfunction

   function automatic turn_sign_type turn_of(longint ax, longint ay, longint bx, longint by,
                                             longint cx, longint cy);
      longint t;
      t = (bx - ax) * (cy - by) - (by - ay) * (cx - bx);
      if (t > 0) return SIGN_POS;
      if (t < 0) return SIGN_NEG;
      return SIGN_NONE;
   endfunction

   function automatic void fold_turn(turn_sign_type s);
      if (s == SIGN_NONE) return;
      if (p_sign == SIGN_NONE) p_sign = s;
      else if (p_sign != s) p_conflict = 1'b1;
   endfunction

   function automatic void clear_tracker();
      p_first_x = '0; p_first_y = '0; p_second_x = '0; p_second_y = '0;
      p_older_x = '0; p_older_y = '0; p_newer_x = '0; p_newer_y = '0;
      p_count = '0;
      p_sign = SIGN_NONE;
      p_conflict = 1'b0;
   endfunction

   function automatic void predict_vertex(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                                          logic last);
      verdict_type v;
      if (p_count >= 2)
         fold_turn(turn_of(p_older_x, p_older_y, p_newer_x, p_newer_y, x, y));
      if (p_count == 0) begin
         p_first_x = x;
         p_first_y = y;
      end else if (p_count == 1) begin
         p_second_x = x;
         p_second_y = y;
      end
      p_older_x = p_newer_x;
      p_older_y = p_newer_y;
      p_newer_x = x;
      p_newer_y = y;
      if (p_count < MIN_VERTICES) p_count = p_count + 2'd1;
      if (!last) return;
      if (p_count < MIN_VERTICES) begin
         v.convex = 1'b0;
         v.error  = 1'b1;
      end else begin
         fold_turn(turn_of(p_older_x, p_older_y, p_newer_x, p_newer_y, p_first_x, p_first_y));
         fold_turn(turn_of(p_newer_x, p_newer_y, p_first_x, p_first_y, p_second_x,
                           p_second_y));
         v.convex = ~p_conflict;
         v.error  = 1'b0;
      end
      expected_verdicts.push_back(v);
      clear_tracker();
   endfunction

   // receiver: random stall, long hold-off on request, verdict check
   always @(posedge clock) begin
      verdict_type want;
      if (rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: verdict expected none actual convex %0b error %0b", $time,
                     rsp_is_convex_flag, rsp_error_code);
            fail_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_is_convex_flag !== want.convex) begin
               $display("%0t: is_convex_flag expected %0b actual %0b", $time,
                        want.convex, rsp_is_convex_flag);
               fail_count++;
            end
            if (rsp_error_code !== want.error) begin
               $display("%0t: error_code expected %0b actual %0b", $time,
                        want.error, rsp_error_code);
               fail_count++;
            end
         end
      end
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_now();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("polygon_convexity_check: mismatch");
            $finish;
         end
      end
   end

   task automatic send_vertex(logic signed [CB-1:0] x, logic signed [CB-1:0] y, logic last);
      if (idle_now()) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while (idle_now()) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_vertex_x    <= x;
      req_vertex_y    <= y;
      req_last_vertex <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_vertex(x, y, last);
   endtask

   function automatic void add_pt(int x, int y);
      point_type p;
      p.x = CB'(x);
      p.y = CB'(y);
      shape_pts.push_back(p);
   endfunction

   task automatic send_shape();
      for (int i = 0; i < shape_pts.size(); i++)
         send_vertex(shape_pts[i].x, shape_pts[i].y, i == shape_pts.size() - 1);
      shape_pts.delete();
   endtask

   // sender pauses until every verdict is back
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int rand_coord(int mode);
      int ext[7];
      ext = '{-32768, -32767, -1, 0, 1, 32766, 32767};
      case (mode)
         0: return int'($signed(CB'($urandom)));
         1: return $urandom_range(4) - 2;
         default: return ext[$urandom_range(6)];
      endcase
   endfunction

   // convex shape from an ordered subset of a scaled octagon
   function automatic void build_octagon();
      int ox[8];
      int oy[8];
      int r, lim, cx, cy, start, k;
      bit rev;
      ox = '{3, 2, 0, -2, -3, -2, 0, 2};
      oy = '{0, 2, 3, 2, 0, -2, -3, -2};
      r = ($urandom_range(3) == 0) ? $urandom_range(10000, 1) : $urandom_range(20, 1);
      lim = 32767 - 3 * r;
      cx = $urandom_range(2 * lim) - lim;
      cy = $urandom_range(2 * lim) - lim;
      start = $urandom_range(7);
      rev = $urandom_range(1);
      for (int i = 0; i < 8; i++) begin
         k = rev ? (start + 8 - i) % 8 : (start + i) % 8;
         if ($urandom_range(9) < 7) add_pt(cx + r * ox[k], cy + r * oy[k]);
      end
      if (shape_pts.size() == 0) add_pt(cx, cy);
   endfunction

   function automatic void build_random_shape();
      int pick, n, mode, x0, y0, dx, dy;
      pick = $urandom_range(99);
      if (pick < 45) begin
         build_octagon();
      end else if (pick < 70) begin
         n = $urandom_range(8, 3);
         mode = ($urandom_range(3) == 0) ? 2 : 0;
         for (int i = 0; i < n; i++) add_pt(rand_coord(mode), rand_coord(mode));
      end else if (pick < 85) begin
         n = $urandom_range(7, 3);
         for (int i = 0; i < n; i++) add_pt(rand_coord(1), rand_coord(1));
      end else if (pick < 95) begin
         n = $urandom_range(2, 1);
         mode = $urandom_range(2);
         for (int i = 0; i < n; i++) add_pt(rand_coord(mode), rand_coord(mode));
      end else begin
         n = $urandom_range(6, 3);
         x0 = $urandom_range(200) - 100;
         y0 = $urandom_range(200) - 100;
         dx = $urandom_range(20) - 10;
         dy = $urandom_range(20) - 10;
         for (int i = 0; i < n; i++) add_pt(x0 + i * dx, y0 + i * dy);
      end
   endfunction

   task automatic run_random_polygons(int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         build_random_shape();
         sent += shape_pts.size();
         send_shape();
      end
   endtask

   task automatic test_short_polygons();
      add_pt(-32768, 32767);
      send_shape();
      add_pt(32767, -32768);
      add_pt(0, 0);
      send_shape();
      drain();
   endtask

   task automatic test_extreme_triangles();
      add_pt(-32768, -32768);
      add_pt(32767, -32768);
      add_pt(32767, 32767);
      send_shape();
      add_pt(32767, 32767);
      add_pt(32767, -32768);
      add_pt(-32768, -32768);
      send_shape();
      drain();
   endtask

   task automatic test_collinear();
      add_pt(-32768, -32768);
      add_pt(0, 0);
      add_pt(32767, 32767);
      add_pt(-1, -1);
      send_shape();
      drain();
   endtask

   task automatic test_concave();
      add_pt(0, 0);
      add_pt(100, 0);
      add_pt(50, 10);
      add_pt(50, 100);
      send_shape();
      add_pt(0, 0);
      add_pt(10, 10);
      add_pt(10, 0);
      add_pt(0, 10);
      send_shape();
      drain();
   endtask

   // conflict shows up only in a closing turn of the first shape; the second is convex
   task automatic test_wrap_conflict();
      add_pt(0, 0);
      add_pt(4, 0);
      add_pt(4, 4);
      add_pt(2, 1);
      send_shape();
      add_pt(32767, 0);
      add_pt(0, 32767);
      add_pt(-32768, 0);
      add_pt(0, -32768);
      send_shape();
      drain();
   endtask

   task automatic test_random();
      run_random_polygons(700);
      drain();
   endtask

   task automatic test_back_to_back();
      idle_en = 1'b0;
      run_random_polygons(150);
      drain();
      idle_en = 1'b1;
   endtask

   // receiver holds off while vertices keep coming, so the queue fills
   task automatic test_backpressure();
      idle_en  = 1'b0;
      hold_req = 1'b1;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 6; j++) add_pt(rand_coord(0), rand_coord(0));
         send_shape();
      end
      idle_en = 1'b1;
      drain();
      run_random_polygons(120);
      drain();
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_vertex_x    = '0;
      req_vertex_y    = '0;
      req_last_vertex = 1'b0;
      rsp_stall       = 1'b0;
      fail_count      = 0;
      idle_en         = 1'b1;
      hold_req        = 1'b0;
      hold_left       = 0;
      quiet_cycles    = 0;
      clear_tracker();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_polygons();
      test_extreme_triangles();
      test_collinear();
      test_concave();
      test_wrap_conflict();
      test_random();
      test_back_to_back();
      test_backpressure();

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_verdicts.size() == 0) begin
         $display("polygon_convexity_check: match");
      end else begin
         $display("polygon_convexity_check: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pcc_pkg.sv
rtl/pcc_front.sv
rtl/pcc_queue.sv
rtl/pcc_back.sv
rtl/polygon_convexity_check.sv
sim/testbench.sv
